// ===== hdl/lpfs_pkg.sv =====
`default_nettype none
package lpfs_pkg;

	// panel geometry
	localparam int unsigned PANEL_W    = 32;
	localparam int unsigned PANEL_H    = 16;

	// bit and byte constants
	localparam logic [7:0] MSB_MASK = 8'h80;
	localparam logic [2:0] BIT_SEL  = 3'h7;
	localparam logic [7:0] BYTE_ONES = 8'hFF;

	// operation codes
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_FILL  = 2'd1,
		OP_SCAN  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WR_RD,
		ST_WR_MOD,
		ST_SCAN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic fill;
		logic px_rd;
		logic px_wr;
		logic scan_go;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_range;
		logic scan_done;
	} sts_t;

endpackage
`default_nettype wire

// ===== hdl/led_panel_framebuffer_scan.sv =====
`default_nettype none
// Frame store and scan driver for PANELS chained 32x16 monochrome LED panels
// with 1/4 scan. Op 0 sets or clears one pixel (msb of a byte is the leftmost
// pixel; writes off the panel are dropped), op 1 fills the whole store with
// 0x00 or 0xFF, op 2 emits 16*PANELS items for row group scan_row: for each
// byte column the rows r+12, r+8, r+4 and r, each byte inverted to pin level,
// with row_lines equal to the group and last set on the final item (latch
// then output enable). Op 3 does nothing. A fill completes on acceptance; a
// pixel write steps through accept, read and modify-write, and one that falls
// off the panel skips the read and the write. In a scan the single read port
// of the frame store delivers one byte a cycle into the output register while
// the receiver does not stall, and the input is stalled until the last byte
// has entered that register. The store is dark after reset.
module led_panel_framebuffer_scan
	import lpfs_pkg::*;
#(
	parameter int unsigned PANELS = 1
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] op,
	input  wire logic [7:0] x,
	input  wire logic [4:0] y,
	input  wire logic       pixel_on,
	input  wire logic       fill_ones,
	input  wire logic [1:0] scan_row,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      shift_byte,
	output logic [1:0]      row_lines,
	output logic            last
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	lpfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// store, scan counters and output register
	lpfs_datapath #(
		.PANELS (PANELS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.op         (op),
		.x          (x),
		.y          (y),
		.pixel_on   (pixel_on),
		.fill_ones  (fill_ones),
		.scan_row   (scan_row),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.shift_byte (shift_byte),
		.row_lines  (row_lines),
		.last       (last)
	);

endmodule
`default_nettype wire

// ===== hdl/lpfs_ram.sv =====
`default_nettype none
module lpfs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/lpfs_ctrl.sv =====
`default_nettype none
module lpfs_ctrl
	import lpfs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] op,
	output logic            in_stall,
	output cmd_t            cmd,
	input  wire sts_t       sts
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_stall    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					unique case (op_t'(op))
						OP_WRITE: state_d = ST_WR_RD;
						OP_FILL:  cmd.fill = 1'b1;
						OP_SCAN:  state_d = ST_SCAN;
						OP_NONE:  state_d = ST_IDLE;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_WR_RD: begin
				// off-panel writes are dropped
				if (sts.in_range) begin
					cmd.px_rd = 1'b1;
					state_d   = ST_WR_MOD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_WR_MOD: begin
				cmd.px_wr = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_SCAN: begin
				cmd.scan_go = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/lpfs_datapath.sv =====
`default_nettype none
module lpfs_datapath
	import lpfs_pkg::*;
#(
	parameter int unsigned PANELS = 1
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cmd_t       cmd,
	output sts_t            sts,
	input  wire logic [1:0] op,
	input  wire logic [7:0] x,
	input  wire logic [4:0] y,
	input  wire logic       pixel_on,
	input  wire logic       fill_ones,
	input  wire logic [1:0] scan_row,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      shift_byte,
	output logic [1:0]      row_lines,
	output logic            last
);

	localparam int unsigned ROW_BYTES = 4 * PANELS;
	localparam int unsigned DEPTH     = PANEL_H * ROW_BYTES;
	localparam int unsigned AW        = $clog2(DEPTH);
	localparam int unsigned CW        = $clog2(ROW_BYTES);
	localparam int unsigned X_LIMIT   = PANEL_W * PANELS;

	// captured item fields
	logic [7:0] x_q;
	logic [4:0] y_q;
	logic       on_q;
	logic [1:0] row_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q   <= x;
			y_q   <= y;
			on_q  <= pixel_on;
			row_q <= scan_row;
		end
	end

	// fill value and per-entry written flags
	logic             fill_q;
	logic [DEPTH-1:0] valid_q;
	logic [AW-1:0]    px_addr;
	logic             px_we;
	logic             in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= 1'b0;
			valid_q <= '0;
		end else if (cmd.fill) begin
			fill_q  <= fill_ones;
			valid_q <= '0;
		end else if (px_we) begin
			valid_q[px_addr] <= 1'b1;
		end
	end

	// pixel address and panel bounds
	assign px_addr  = AW'(x_q[7:3]) + AW'(y_q[3:0]) * AW'(ROW_BYTES);
	assign in_range = ({1'b0, x_q} < 9'(X_LIMIT)) && !y_q[4];

	// scan sequencing: byte column c, then rows r+12, r+8, r+4, r
	logic [CW-1:0] c_q;
	logic [1:0]    k_q;
	logic          issued_all_q;
	logic          pend_q;
	logic          out_valid_q;
	logic          load;
	logic          issue;
	logic          issue_last;
	logic          scan_done;
	logic [AW-1:0] scan_addr;

	assign load       = pend_q && (!out_valid_q || !out_stall);
	assign issue      = cmd.scan_go && !issued_all_q && (!pend_q || load);
	assign issue_last = (c_q == CW'(ROW_BYTES - 1)) && (k_q == 2'd3);
	assign scan_addr  = AW'(row_q) * AW'(ROW_BYTES) + AW'(c_q)
		+ AW'(2'd3 - k_q) * AW'(4 * ROW_BYTES);
	assign scan_done  = issued_all_q && !pend_q;

	// status back to the controller
	assign sts = {in_range, scan_done};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q          <= '0;
			k_q          <= '0;
			issued_all_q <= 1'b1;
			pend_q       <= 1'b0;
		end else begin
			if (cmd.capture && (op_t'(op) == OP_SCAN)) begin
				c_q          <= '0;
				k_q          <= '0;
				issued_all_q <= 1'b0;
			end else if (issue) begin
				k_q <= k_q + 2'd1;
				if (k_q == 2'd3) begin
					c_q <= c_q + CW'(1);
				end
				if (issue_last) begin
					issued_all_q <= 1'b1;
				end
			end
			if (issue) begin
				pend_q <= 1'b1;
			end else if (load) begin
				pend_q <= 1'b0;
			end
		end
	end

	// frame store, shared read port
	logic          re;
	logic [AW-1:0] raddr;
	logic [7:0]    rd_data;
	logic          valid_s1;
	logic          last_s1;
	logic [7:0]    byte_s1;
	logic [7:0]    mask;
	logic [7:0]    wdata;

	assign re    = issue || cmd.px_rd;
	assign raddr = issue ? scan_addr : px_addr;
	assign px_we = cmd.px_wr;

	always_ff @(posedge clk) begin
		if (re) begin
			valid_s1 <= valid_q[raddr];
			last_s1  <= issue_last;
		end
	end

	assign byte_s1 = valid_s1 ? rd_data : (fill_q ? BYTE_ONES : ~BYTE_ONES);

	// read-modify-write of one pixel bit, msb first
	assign mask  = MSB_MASK >> (x_q[2:0] & BIT_SEL);
	assign wdata = on_q ? (byte_s1 | mask) : (byte_s1 & ~mask);

	lpfs_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (px_we),
		.waddr (px_addr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rd_data)
	);

	// output register
	logic [7:0] shift_byte_q;
	logic [1:0] row_lines_q;
	logic       last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shift_byte_q <= ~byte_s1;
			row_lines_q  <= row_q;
			last_q       <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign shift_byte = shift_byte_q;
	assign row_lines  = row_lines_q;
	assign last       = last_q;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
	import lpfs_pkg::*;

	localparam int unsigned PANELS        = 1;
	localparam int unsigned ROW_BYTES     = 4 * PANELS;
	localparam int unsigned STORE_BYTES   = 64 * PANELS;
	localparam int unsigned SCAN_BYTES    = 16 * PANELS;
	localparam int unsigned SETTLE_CYCLES = 2 * (SCAN_BYTES + 3) + 8;
	localparam int unsigned IDLE_LIMIT    = 4000;
	localparam int unsigned RANDOM_ITEMS  = 360;

	// one byte shifted out towards the panel
	typedef struct packed {
		logic [7:0] shift_byte;
		logic [1:0] row_lines;
		logic       last;
	} panel_byte_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [1:0] op        = OP_NONE;
	logic [7:0] x         = 8'd0;
	logic [4:0] y         = 5'd0;
	logic       pixel_on  = 1'b0;
	logic       fill_ones = 1'b0;
	logic [1:0] scan_row  = 2'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] shift_byte;
	logic [1:0] row_lines;
	logic       last;

	// own copy of the frame store and the bytes still to come out
	logic [7:0]  frame_copy [STORE_BYTES];
	panel_byte_t panel_bytes_due [$];

	int mismatch_count = 0;
	int burst_left     = 0;
	int stall_mode     = 0;
	int stall_left     = 0;
	int idle_cycles    = 0;

	led_panel_framebuffer_scan #(
		.PANELS(PANELS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.x         (x),
		.y         (y),
		.pixel_on  (pixel_on),
		.fill_ones (fill_ones),
		.scan_row  (scan_row),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.shift_byte(shift_byte),
		.row_lines (row_lines),
		.last      (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// apply one accepted item to the frame copy, queue the bytes a scan emits
	function automatic void predict_panel(logic [1:0] code, logic [7:0] px,
		logic [4:0] py, logic on, logic ones, logic [1:0] grp);
		int unsigned idx;
		panel_byte_t b;
		case (code)
		OP_WRITE: begin
			if (px < PANEL_W * PANELS && py < PANEL_H) begin
				idx = px / 8 + py * ROW_BYTES;
				if (on)
					frame_copy[idx] = frame_copy[idx] | (MSB_MASK >> (px & BIT_SEL));
				else
					frame_copy[idx] = frame_copy[idx] & ~(MSB_MASK >> (px & BIT_SEL));
			end
		end
		OP_FILL: begin
			for (int i = 0; i < STORE_BYTES; i++)
				frame_copy[i] = ones ? BYTE_ONES : 8'h00;
		end
		OP_SCAN: begin
			// rows r+12, r+8, r+4, r for each byte column
			for (int c = 0; c < ROW_BYTES; c++) begin
				for (int k = 0; k < 4; k++) begin
					idx = grp * ROW_BYTES + c + (3 - k) * 4 * ROW_BYTES;
					b.shift_byte = ~frame_copy[idx];
					b.row_lines  = grp;
					b.last       = (c == ROW_BYTES - 1) && (k == 3);
					panel_bytes_due.push_back(b);
				end
			end
		end
		default: begin
		end
		endcase
	endfunction

	// drive one item, wait for acceptance, then keep the burst going or pause
	task automatic send_item(logic [1:0] code, logic [7:0] px, logic [4:0] py,
		logic on, logic ones, logic [1:0] grp);
		in_valid  <= 1'b1;
		op        <= code;
		x         <= px;
		y         <= py;
		pixel_on  <= on;
		fill_ones <= ones;
		scan_row  <= grp;
		do @(posedge clk); while (!(in_valid && !in_stall));
		predict_panel(code, px, py, on, ones, grp);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			if ($urandom_range(0, 3) == 0)
				burst_left = $urandom_range(20, 60);
			else
				burst_left = $urandom_range(0, 8);
		end
	endtask

	// stop sending, wait for every due byte, then let the block settle
	task automatic settle_block();
		in_valid <= 1'b0;
		while (panel_bytes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_dark_after_reset();
		send_item(OP_SCAN, 8'($urandom), 5'($urandom), 1'($urandom), 1'($urandom), 2'd0);
		send_item(OP_SCAN, 8'($urandom), 5'($urandom), 1'($urandom), 1'($urandom), 2'd3);
		settle_block();
	endtask

	task automatic test_pixel_writes();
		// corners, inner pixels and a clear of a set pixel
		send_item(OP_WRITE, 8'd0, 5'd0, 1'b1, 1'($urandom), 2'($urandom));
		send_item(OP_WRITE, 8'd31, 5'd15, 1'b1, 1'($urandom), 2'($urandom));
		send_item(OP_WRITE, 8'd9, 5'd5, 1'b1, 1'($urandom), 2'($urandom));
		send_item(OP_WRITE, 8'd17, 5'd10, 1'b1, 1'($urandom), 2'($urandom));
		send_item(OP_WRITE, 8'd24, 5'd14, 1'b1, 1'($urandom), 2'($urandom));
		send_item(OP_WRITE, 8'd9, 5'd5, 1'b0, 1'($urandom), 2'($urandom));
		// writes off the panel change nothing
		send_item(OP_WRITE, 8'd32, 5'd0, 1'b1, 1'($urandom), 2'($urandom));
		send_item(OP_WRITE, 8'd255, 5'd3, 1'b1, 1'($urandom), 2'($urandom));
		send_item(OP_WRITE, 8'd5, 5'd16, 1'b1, 1'($urandom), 2'($urandom));
		send_item(OP_WRITE, 8'd5, 5'd31, 1'b1, 1'($urandom), 2'($urandom));
		for (int g = 0; g < 4; g++)
			send_item(OP_SCAN, 8'($urandom), 5'($urandom), 1'($urandom), 1'($urandom),
				2'(g));
		settle_block();
	endtask

	task automatic test_fill_and_unused_op();
		send_item(OP_FILL, 8'($urandom), 5'($urandom), 1'($urandom), 1'b1, 2'($urandom));
		send_item(OP_SCAN, 8'($urandom), 5'($urandom), 1'($urandom), 1'($urandom), 2'd2);
		send_item(OP_WRITE, 8'd8, 5'd6, 1'b0, 1'($urandom), 2'($urandom));
		send_item(OP_SCAN, 8'($urandom), 5'($urandom), 1'($urandom), 1'($urandom), 2'd2);
		// unused opcode leaves the store alone
		send_item(OP_NONE, 8'($urandom), 5'($urandom), 1'($urandom), 1'($urandom),
			2'($urandom));
		send_item(OP_FILL, 8'($urandom), 5'($urandom), 1'($urandom), 1'b0, 2'($urandom));
		send_item(OP_SCAN, 8'($urandom), 5'($urandom), 1'($urandom), 1'($urandom), 2'd3);
		settle_block();
	endtask

	task automatic test_random_traffic();
		int pick;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				send_item(OP_WRITE, 8'($urandom_range(0, PANEL_W * PANELS - 1)),
					5'($urandom_range(0, PANEL_H - 1)), $urandom_range(0, 9) < 7,
					1'($urandom), 2'($urandom));
			else if (pick < 65)
				send_item(OP_WRITE, 8'($urandom), 5'($urandom), 1'($urandom),
					1'($urandom), 2'($urandom));
			else if (pick < 70)
				send_item(OP_FILL, 8'($urandom), 5'($urandom), 1'($urandom),
					1'($urandom), 2'($urandom));
			else if (pick < 94)
				send_item(OP_SCAN, 8'($urandom), 5'($urandom), 1'($urandom),
					1'($urandom), 2'($urandom));
			else
				send_item(OP_NONE, 8'($urandom), 5'($urandom), 1'($urandom),
					1'($urandom), 2'($urandom));
		end
		settle_block();
	endtask

	// receiver back-pressure: modes of random length
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(16, 96);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
		0: out_stall <= 1'b0;
		1: out_stall <= ($urandom_range(0, 99) < 30);
		2: out_stall <= ($urandom_range(0, 99) < 75);
		default: out_stall <= (stall_left[2:0] < 3'd3);
		endcase
	end

	// compare each emitted byte with the oldest due one
	always @(posedge clk) begin
		panel_byte_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (panel_bytes_due.size() == 0) begin
				$display("%0t unexpected byte: expected none, actual %02h row %0d last %0b",
					$time, shift_byte, row_lines, last);
				mismatch_count++;
			end else begin
				want = panel_bytes_due.pop_front();
				if (shift_byte !== want.shift_byte) begin
					$display("%0t shift_byte: expected %02h, actual %02h",
						$time, want.shift_byte, shift_byte);
					mismatch_count++;
				end
				if (row_lines !== want.row_lines) begin
					$display("%0t row_lines: expected %0d, actual %0d",
						$time, want.row_lines, row_lines);
					mismatch_count++;
				end
				if (last !== want.last) begin
					$display("%0t last: expected %0b, actual %0b", $time, want.last, last);
					mismatch_count++;
				end
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else if (arst_n)
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t timeout with %0d bytes due", $time, panel_bytes_due.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < STORE_BYTES; i++)
			frame_copy[i] = 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_dark_after_reset();
		test_pixel_writes();
		test_fill_and_unused_op();
		test_random_traffic();
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/lpfs_pkg.sv
hdl/lpfs_ram.sv
hdl/lpfs_ctrl.sv
hdl/lpfs_datapath.sv
hdl/led_panel_framebuffer_scan.sv
tb/sv/tb_top.sv
